@@ hw/rtl/wlrm_pkg.sv @@
package wlrm_pkg;

    // Field widths of the event and result transactions.
    localparam int LAT_W   = 24;
    localparam int STAMP_W = 48;
    localparam int RATE_W  = 32;
    localparam int TOT_W   = 64;

    // One frame per microsecond, in Q8: 1e6 * 256.
    localparam longint unsigned RATE_SCALE = 64'd256000000;
    localparam int              SCALE_W    = 28;

    // Event codes.
    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_DROP  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hw/rtl/wlrm_ram.sv @@
module wlrm_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/wlrm_div.sv @@
module wlrm_div #(
    parameter int DIV_W = 35
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DIV_W-1:0]             num,
    input  logic [wlrm_pkg::STAMP_W-1:0] den,
    output logic [DIV_W-1:0]             quo,
    output wlrm_pkg::div_stat_t          stat
);

    localparam int DEN_W = wlrm_pkg::STAMP_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;

    logic [DEN_W:0]   partial;
    logic [DEN_W+1:0] diff;
    logic             fits;

    // One restoring step: bring down the next numerator bit and try the divisor.
    assign partial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, den_reg};
    assign fits    = ~diff[DEN_W+1];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // A start always begins a run.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

    // Completion is flagged only once the run has ended.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    // A running divider always has steps left.
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero step count");

endmodule

@@ hw/rtl/windowed_latency_and_rate_monitor.sv @@
// Channel   Direction  Handshake              Payload
// event     in         in_valid / in_ready    opcode, latency, stamp_us
// result    out        out_valid / out_ready  avg_latency, rate_fps_q8, frames_total,
//                                             drops_total
//
// A frame reads the old entry, updates the window, reads the newest and oldest stamps, sets
// up, divides for the mean and the rate and loads the output; other events skip the first of
// the three ring reads. The shared one-bit-per-cycle divider runs first for the mean and then
// for the rate. The rate division is skipped under two samples or at zero elapsed time, and
// an empty window skips both divisions.
// Reset clears the counters, the window and the sequencer; the ring memory is not cleared.
// The next event is taken while a finished result still waits on out_ready, but it holds
// in its last step until that result is taken.
module windowed_latency_and_rate_monitor #(
    parameter int WINDOW = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [23:0] latency,
    input  logic [47:0] stamp_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] avg_latency,
    output logic [31:0] rate_fps_q8,
    output logic [63:0] frames_total,
    output logic [63:0] drops_total
);

    localparam int LAT_W   = wlrm_pkg::LAT_W;
    localparam int STAMP_W = wlrm_pkg::STAMP_W;
    localparam int RATE_W  = wlrm_pkg::RATE_W;
    localparam int TOT_W   = wlrm_pkg::TOT_W;
    localparam int AW      = $clog2(WINDOW);
    localparam int FW      = $clog2(WINDOW + 1);
    localparam int SUM_W   = LAT_W + FW;
    localparam int PW      = FW + wlrm_pkg::SCALE_W;
    localparam logic [63:0] RNUM_MAX = 64'(WINDOW - 1) * wlrm_pkg::RATE_SCALE;
    localparam int RNUM_W  = $clog2(RNUM_MAX + 64'd1);
    localparam int DIV_W   = (SUM_W > RNUM_W) ? SUM_W : RNUM_W;
    localparam int MEM_W   = LAT_W + STAMP_W;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_RD_OLD   = 9'b000000010,
        ST_UPDATE   = 9'b000000100,
        ST_RD_NEW   = 9'b000001000,
        ST_RD_FIRST = 9'b000010000,
        ST_SETUP    = 9'b000100000,
        ST_DIV_AVG  = 9'b001000000,
        ST_DIV_RATE = 9'b010000000,
        ST_LOAD     = 9'b100000000
    } state_t;

    state_t              state_reg,   state_next;
    wlrm_pkg::op_t       op_reg,      op_next;
    logic [LAT_W-1:0]    lat_reg,     lat_next;
    logic [STAMP_W-1:0]  stamp_reg,   stamp_next;
    logic [AW-1:0]       slot_reg,    slot_next;
    logic [FW-1:0]       fill_reg,    fill_next;
    logic [SUM_W-1:0]    sum_reg,     sum_next;
    logic [TOT_W-1:0]    frame_reg,   frame_next;
    logic [TOT_W-1:0]    drop_reg,    drop_next;
    logic [STAMP_W-1:0]  newest_reg,  newest_next;
    logic [STAMP_W-1:0]  elapsed_reg, elapsed_next;
    logic [RNUM_W-1:0]   prod_reg,    prod_next;
    logic [LAT_W-1:0]    avg_reg,     avg_next;
    logic [RATE_W-1:0]   rate_reg,    rate_next;
    logic                out_valid_reg, out_valid_next;
    logic [LAT_W-1:0]    out_avg_reg,   out_avg_next;
    logic [RATE_W-1:0]   out_rate_reg,  out_rate_next;
    logic [TOT_W-1:0]    out_frame_reg, out_frame_next;
    logic [TOT_W-1:0]    out_drop_reg,  out_drop_next;

    logic                full;
    logic [AW-1:0]       newest_slot;
    logic [AW-1:0]       oldest_slot;
    logic [AW-1:0]       rd_addr;
    logic [MEM_W-1:0]    rd_data;
    logic                wr_en;
    logic [LAT_W-1:0]    rd_lat;
    logic [STAMP_W-1:0]  rd_stamp;
    logic                div_start;
    logic [DIV_W-1:0]    div_num;
    logic [STAMP_W-1:0]  div_den;
    logic [DIV_W-1:0]    div_quo;
    logic [63:0]         quo_wide;
    wlrm_pkg::div_stat_t div_stat;
    logic                out_free;
    logic [FW-1:0]       fill_less1;

    // Ring addressing: the oldest entry sits at slot 0 until the window fills.
    assign full        = (fill_reg == FW'(WINDOW));
    assign newest_slot = (slot_reg == '0) ? AW'(WINDOW - 1) : slot_reg - AW'(1);
    assign oldest_slot = full ? slot_reg : '0;
    assign rd_lat      = rd_data[MEM_W-1:STAMP_W];
    assign rd_stamp    = rd_data[STAMP_W-1:0];
    assign wr_en       = (state_reg == ST_UPDATE) && (op_reg == wlrm_pkg::OP_FRAME);
    assign fill_less1  = fill_reg - FW'(1);
    assign quo_wide    = 64'(div_quo);
    assign out_free    = !out_valid_reg || out_ready;

    // Read address follows the sequencer step.
    always_comb
    begin
        if (state_reg == ST_RD_OLD)
        begin
            rd_addr = slot_reg;
        end
        else if (state_reg == ST_RD_NEW)
        begin
            rd_addr = newest_slot;
        end
        else
        begin
            rd_addr = oldest_slot;
        end
    end

    wlrm_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data ({lat_reg, stamp_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Divider operands: the mean first, then the rate.
    assign div_num   = (state_reg == ST_SETUP) ? DIV_W'(sum_reg) : DIV_W'(prod_reg);
    assign div_den   = (state_reg == ST_SETUP) ? STAMP_W'(fill_reg) : elapsed_reg;
    assign div_start = ((state_reg == ST_SETUP) && (fill_reg != '0))
                    || ((state_reg == ST_DIV_AVG) && div_stat.done
                        && (fill_reg >= FW'(2)) && (elapsed_reg != '0));

    wlrm_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // Sequencer and window update.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        lat_next       = lat_reg;
        stamp_next     = stamp_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        frame_next     = frame_reg;
        drop_next      = drop_reg;
        newest_next    = newest_reg;
        elapsed_next   = elapsed_reg;
        prod_next      = prod_reg;
        avg_next       = avg_reg;
        rate_next      = rate_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_avg_next   = out_avg_reg;
        out_rate_next  = out_rate_reg;
        out_frame_next = out_frame_reg;
        out_drop_next  = out_drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = wlrm_pkg::op_t'(opcode);
                    lat_next   = latency;
                    stamp_next = stamp_us;
                    state_next = (wlrm_pkg::op_t'(opcode) == wlrm_pkg::OP_FRAME)
                               ? ST_RD_OLD : ST_UPDATE;
                end
            end
            ST_RD_OLD:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                case (op_reg)
                    wlrm_pkg::OP_FRAME:
                    begin
                        if (full)
                        begin
                            sum_next = sum_reg - SUM_W'(rd_lat) + SUM_W'(lat_reg);
                        end
                        else
                        begin
                            fill_next = fill_reg + FW'(1);
                            sum_next  = sum_reg + SUM_W'(lat_reg);
                        end
                        slot_next  = (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + AW'(1);
                        frame_next = frame_reg + TOT_W'(1);
                    end
                    wlrm_pkg::OP_DROP:
                    begin
                        drop_next = drop_reg + TOT_W'(1);
                    end
                    wlrm_pkg::OP_CLEAR:
                    begin
                        slot_next  = '0;
                        fill_next  = '0;
                        sum_next   = '0;
                        frame_next = '0;
                        drop_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_RD_NEW;
            end
            ST_RD_NEW:
            begin
                state_next = ST_RD_FIRST;
            end
            ST_RD_FIRST:
            begin
                newest_next = rd_stamp;
                state_next  = ST_SETUP;
            end
            ST_SETUP:
            begin
                elapsed_next = newest_reg - rd_stamp;
                prod_next    = RNUM_W'(PW'(fill_less1) * PW'(wlrm_pkg::RATE_SCALE));
                if (fill_reg == '0)
                begin
                    avg_next   = '0;
                    rate_next  = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_DIV_AVG;
                end
            end
            ST_DIV_AVG:
            begin
                if (div_stat.done)
                begin
                    avg_next = div_quo[LAT_W-1:0];
                    if (fill_reg < FW'(2))
                    begin
                        rate_next  = '0;
                        state_next = ST_LOAD;
                    end
                    else if (elapsed_reg == '0)
                    begin
                        rate_next  = '1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_DIV_RATE;
                    end
                end
            end
            ST_DIV_RATE:
            begin
                if (div_stat.done)
                begin
                    rate_next  = (|quo_wide[63:32]) ? '1 : quo_wide[31:0];
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = avg_reg;
                    out_rate_next  = rate_reg;
                    out_frame_next = frame_reg;
                    out_drop_next  = drop_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and window bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            frame_reg     <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            frame_reg     <= frame_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Captured event fields, intermediates and the output register.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        lat_reg       <= lat_next;
        stamp_reg     <= stamp_next;
        newest_reg    <= newest_next;
        elapsed_reg   <= elapsed_next;
        prod_reg      <= prod_next;
        avg_reg       <= avg_next;
        rate_reg      <= rate_next;
        out_avg_reg   <= out_avg_next;
        out_rate_reg  <= out_rate_next;
        out_frame_reg <= out_frame_next;
        out_drop_reg  <= out_drop_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign avg_latency  = out_avg_reg;
    assign rate_fps_q8  = out_rate_reg;
    assign frames_total = out_frame_reg;
    assign drops_total  = out_drop_reg;

    // The window never holds more than WINDOW entries.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WINDOW))
        else $error("fill count above window depth");

    // Until the window fills, the write slot tracks the fill count.
    a_slot_track: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < FW'(WINDOW)) |-> (slot_reg == AW'(fill_reg)))
        else $error("write slot out of step with fill count");

    // A clear empties the window and its sum.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPDATE) && (op_reg == wlrm_pkg::OP_CLEAR))
        |=> ((fill_reg == '0) && (sum_reg == '0) && (frame_reg == '0)))
        else $error("clear left the window populated");

    // The shared divider is never restarted mid-run.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule

@@ tb/windowed_latency_and_rate_monitor_tb.sv @@
module windowed_latency_and_rate_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LAT_W        = wlrm_pkg::LAT_W;
    localparam int          STAMP_W      = wlrm_pkg::STAMP_W;
    localparam int          RATE_W       = wlrm_pkg::RATE_W;
    localparam int          TOT_W        = wlrm_pkg::TOT_W;
    localparam int          WIN          = 128;
    localparam int          RAND_ITEMS   = 900;
    localparam int          QUIET_ITEMS  = 150;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          DRAIN_CYCLES = 160;
    localparam int unsigned LIMIT_CYCLES = 600000;

    // One result transaction of the monitor.
    typedef struct packed {
        logic [LAT_W-1:0]  avg;
        logic [RATE_W-1:0] rate;
        logic [TOT_W-1:0]  frames;
        logic [TOT_W-1:0]  drops;
    } stats_t;

    // Tracks the window contents and holds the statistics each event should produce.
    class stats_scoreboard;
        logic [LAT_W-1:0]   lat_ring [WIN];
        logic [STAMP_W-1:0] stamp_ring [WIN];
        int unsigned        slot;
        int unsigned        fill;
        longint unsigned    lat_sum;
        logic [TOT_W-1:0]   frames;
        logic [TOT_W-1:0]   drops;
        stats_t             expected_stats [$];
        int unsigned        mismatches;

        function new();
            slot       = 0;
            fill       = 0;
            lat_sum    = 0;
            frames     = '0;
            drops      = '0;
            mismatches = 0;
        endfunction

        // Frame rate over the window in Q8, saturating at the top of the range.
        function logic [RATE_W-1:0] window_rate();
            int unsigned        newest;
            int unsigned        oldest;
            logic [STAMP_W-1:0] span;
            longint unsigned    intervals;
            longint unsigned    q;
            if (fill < 2)
                return '0;
            newest = (slot + WIN - 1) % WIN;
            oldest = (slot + WIN - fill) % WIN;
            span = stamp_ring[newest] - stamp_ring[oldest];
            if (span == '0)
                return '1;
            intervals = fill - 1;
            q = (intervals * wlrm_pkg::RATE_SCALE) / {16'd0, span};
            if (q > 64'hFFFF_FFFF)
                return '1;
            return q[RATE_W-1:0];
        endfunction

        // Applies one accepted event and queues the statistics it must report.
        function void note_event(wlrm_pkg::op_t op, logic [LAT_W-1:0] lat,
                                 logic [STAMP_W-1:0] stamp);
            stats_t want;
            case (op)
                wlrm_pkg::OP_FRAME:
                begin
                    // A full window drops its oldest latency from the sum first.
                    if (fill >= WIN)
                        lat_sum -= lat_ring[slot];
                    else
                        fill++;
                    lat_ring[slot]   = lat;
                    stamp_ring[slot] = stamp;
                    lat_sum += lat;
                    slot = (slot + 1) % WIN;
                    frames++;
                end
                wlrm_pkg::OP_DROP: drops++;
                wlrm_pkg::OP_CLEAR:
                begin
                    slot    = 0;
                    fill    = 0;
                    lat_sum = 0;
                    frames  = '0;
                    drops   = '0;
                end
                default: ;
            endcase
            want.avg    = (fill != 0) ? LAT_W'(lat_sum / fill) : '0;
            want.rate   = window_rate();
            want.frames = frames;
            want.drops  = drops;
            expected_stats.insert(expected_stats.size(), want);
        endfunction

        // Compares one result transaction against the oldest expectation.
        function void check_result(stats_t got);
            stats_t want;
            bit     bad;
            if (expected_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: avg %0d rate %0d",
                             $realtime, got.avg, got.rate,
                             " frames %0d drops %0d", got.frames, got.drops);
                return;
            end
            want = expected_stats[0];
            expected_stats.delete(0);
            bad = (got.avg !== want.avg) || (got.rate !== want.rate) ||
                  (got.frames !== want.frames) || (got.drops !== want.drops);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch avg_latency exp %0d got %0d",
                             $realtime, want.avg, got.avg,
                             ", rate_fps_q8 exp %0d got %0d", want.rate, got.rate);
                    $display("    frames_total exp %0d got %0d, drops_total exp %0d got %0d",
                             want.frames, got.frames, want.drops, got.drops);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [LAT_W-1:0]   latency;
    logic [STAMP_W-1:0] stamp_us;
    logic               out_valid;
    logic               out_ready;
    logic [LAT_W-1:0]   avg_latency;
    logic [RATE_W-1:0]  rate_fps_q8;
    logic [TOT_W-1:0]   frames_total;
    logic [TOT_W-1:0]   drops_total;

    stats_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              hold_requests = 0;

    windowed_latency_and_rate_monitor #(
        .WINDOW(WIN)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .latency      (latency),
        .stamp_us     (stamp_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .avg_latency  (avg_latency),
        .rate_fps_q8  (rate_fps_q8),
        .frames_total (frames_total),
        .drops_total  (drops_total)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [LAT_W-1:0] rand_lat();
        return LAT_W'($urandom());
    endfunction

    function automatic logic [STAMP_W-1:0] rand_stamp();
        return STAMP_W'({$urandom(), $urandom()});
    endfunction

    // Latencies lean toward the extremes now and then.
    function automatic logic [LAT_W-1:0] next_latency();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return rand_lat();
        else if (pick < 8)
            return '1;
        else
            return LAT_W'($urandom_range(0, 255));
    endfunction

    // Time between frames: mostly video-like, sometimes zero, tiny, huge or wrapping.
    function automatic logic [STAMP_W-1:0] next_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return STAMP_W'($urandom_range(1, 40000));
        else if (pick < 16)
            return '0;
        else if (pick < 18)
            return STAMP_W'($urandom_range(1, 4));
        else if (pick == 18)
            return rand_stamp();
        else
            return 48'hFFFF_FFFF_FFFF - STAMP_W'($urandom_range(0, 1000));
    endfunction

    // Offers one event transaction and waits until it is accepted.
    task automatic send_event(wlrm_pkg::op_t op, logic [LAT_W-1:0] lat,
                              logic [STAMP_W-1:0] stamp);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        latency  <= lat;
        stamp_us <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_event(op, lat, stamp);
    endtask

    // Result side: random stalls, one long hold on request, checks every transaction.
    initial
    begin : result_sink
        int     stall_left;
        int     hold_served;
        stats_t got;
        stall_left  = 0;
        hold_served = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.avg    = avg_latency;
                got.rate   = rate_fps_q8;
                got.frames = frames_total;
                got.drops  = drops_total;
                sb.check_result(got);
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                stall_left  = HOLD_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Cycle limit on the whole run.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles <= LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("windowed_latency_and_rate_monitor_tb: FAIL");
        $finish;
    end

    // Reset, directed events, random events, drain and verdict.
    initial
    begin : stimulus
        logic [STAMP_W-1:0] now_us;
        logic [STAMP_W-1:0] base;
        wlrm_pkg::op_t      op;
        int                 pick;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        opcode   <= wlrm_pkg::OP_FRAME;
        latency  <= '0;
        stamp_us <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An ignored opcode on an empty window, then two frames at the same instant.
        send_event(wlrm_pkg::OP_NOP, rand_lat(), rand_stamp());
        send_event(wlrm_pkg::OP_FRAME, '0, '0);
        send_event(wlrm_pkg::OP_FRAME, '1, '0);
        send_event(wlrm_pkg::OP_DROP, rand_lat(), rand_stamp());
        send_event(wlrm_pkg::OP_CLEAR, rand_lat(), rand_stamp());

        // Timestamps that wrap past the top of the counter.
        send_event(wlrm_pkg::OP_FRAME, '1, 48'hFFFF_FFFF_FFF0);
        send_event(wlrm_pkg::OP_FRAME, '1, 48'h0000_0000_0010);
        send_event(wlrm_pkg::OP_CLEAR, rand_lat(), rand_stamp());

        // Many frames over one microsecond push the quotient past the rate limit.
        base = rand_stamp();
        for (int k = 0; k < 17; k++)
            send_event(wlrm_pkg::OP_FRAME, rand_lat(), base);
        send_event(wlrm_pkg::OP_FRAME, rand_lat(), base + STAMP_W'(1));

        // Random traffic: mostly frames on a running clock, with drops, clears and noise.
        now_us = rand_stamp();
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            if (i == 300)
                hold_requests++;
            pick = $urandom_range(0, 199);
            if (pick == 0 && i > 200)
                op = wlrm_pkg::OP_CLEAR;
            else if (pick >= 1 && pick < 8)
                op = wlrm_pkg::OP_NOP;
            else if (pick >= 8 && pick < 28)
                op = wlrm_pkg::OP_DROP;
            else
                op = wlrm_pkg::OP_FRAME;
            if (op == wlrm_pkg::OP_FRAME)
            begin
                now_us = now_us + next_gap();
                send_event(op, next_latency(), now_us);
            end
            else
                send_event(op, rand_lat(), rand_stamp());
        end
        in_valid <= 1'b0;

        // Let every outstanding result arrive, then watch for strays.
        while (sb.expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_stats.size() == 0)
            $display("windowed_latency_and_rate_monitor_tb: PASS");
        else
            $display("windowed_latency_and_rate_monitor_tb: FAIL");
        $finish;
    end

endmodule
